[sv/ifd_pkg.sv]
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants for the interpolated feedback delay line.
// ----------------------------------------------------------------------------
package ifd_pkg;

  localparam int unsigned LEN_BITS      = 15;
  localparam int unsigned DELAY_BITS    = 30;
  localparam int unsigned GAIN_BITS     = 16;
  localparam int unsigned GAIN_FRAC     = 14;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 30;

  localparam logic [LEN_BITS-1:0]          LEN_RESET   = 15'd4411;
  localparam logic [DELAY_BITS-1:0]        DELAY_RESET = 30'd289013760;
  localparam logic signed [GAIN_BITS-1:0]  GAIN_RESET  = 16'sd1638;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BUFFER_LENGTH     = 3'd0,
    CFG_DEFAULT_DELAY     = 3'd1,
    CFG_DEFAULT_FEEDBACK  = 3'd2,
    CFG_USE_ITEM_DELAY    = 3'd3,
    CFG_USE_ITEM_FEEDBACK = 3'd4
  } cfg_idx_e;

endpackage

[sv/interpolated_feedback_delay.sv]
// ----------------------------------------------------------------------------
// interpolated_feedback_delay
// An accepted beat steps through S_RP, S_RD, S_DIF, S_MUL1, S_Y, S_MUL2 and
// S_WR (held while the output is stalled) before the next input is taken: one
// two-port store read and two passes of a single shared multiplier.
// Reset: config takes its reset values, the write position goes to zero and
// a clearing pass zeroes the store with input stalled.
// ----------------------------------------------------------------------------
module interpolated_feedback_delay import ifd_pkg::*; #(
  parameter int unsigned STORE_DEPTH   = 16384,
  parameter int unsigned SAMPLE_BITS   = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]         cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0]        cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_i,
  input  logic [DELAY_BITS-1:0]           delay_samples_i,
  input  logic signed [GAIN_BITS-1:0]     feedback_gain_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]   wet_sample_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned IW = DELAY_BITS - FRACTION_BITS;
  localparam int unsigned MB = (FRACTION_BITS + 1 > GAIN_BITS) ? FRACTION_BITS + 1 : GAIN_BITS;
  localparam int unsigned PW = SAMPLE_BITS + 1 + MB;

  localparam logic signed [PW-1:0] SAT_HI =
    PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SAT_LO =
    PW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RP, S_RD, S_DIF, S_MUL1, S_Y, S_MUL2, S_WR
  } state_e;

  // configuration registers
  logic [LEN_BITS-1:0]          cfg_len_q;
  logic [DELAY_BITS-1:0]        cfg_delay_q;
  logic signed [GAIN_BITS-1:0]  cfg_fb_q;
  logic                         cfg_use_delay_q;
  logic                         cfg_use_fb_q;

  // sequencer and datapath registers
  state_e                        state_q;
  logic [AW-1:0]                 clr_q;
  logic [AW-1:0]                 wp_q;
  logic [AW-1:0]                 cur_wp_q;
  logic [AW-1:0]                 idel_q;
  logic [AW-1:0]                 rp_q;
  logic [FRACTION_BITS-1:0]      frac_q;
  logic signed [GAIN_BITS-1:0]   gain_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] s1_q;
  logic signed [SAMPLE_BITS:0]   diff_q;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic signed [PW-1:0]          prod_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] wet_sample_q;

  // delay store
  logic signed [SAMPLE_BITS-1:0] store_q [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd1_q;
  logic signed [SAMPLE_BITS-1:0] rd2_q;

  logic [AW:0]                   len_eff;
  logic [DELAY_BITS-1:0]         delay_sel;
  logic [IW-1:0]                 idel_raw;
  logic [AW-1:0]                 idel_clamp;
  logic [AW-1:0]                 wp_clamp;
  logic [AW:0]                   rp_sum;
  logic [AW:0]                   rp2_inc;
  logic [AW-1:0]                 rp2;
  logic [AW:0]                   wp_inc;
  logic signed [SAMPLE_BITS:0]   mul_a;
  logic signed [MB-1:0]          mul_b;
  logic signed [PW-1:0]          mul_p;
  logic signed [PW-1:0]          y_wide;
  logic signed [PW-1:0]          sum_wide;
  logic signed [SAMPLE_BITS-1:0] wr_val;
  logic                          in_acc;
  logic                          commit;
  logic                          mem_we;
  logic [AW-1:0]                 mem_wa;
  logic signed [SAMPLE_BITS-1:0] mem_wd;

  // effective wrap point: zero reads as one, capped at the store depth
  always_comb begin
    priority if (cfg_len_q == '0) begin
      len_eff = (AW+1)'(1);
    end else if (32'(cfg_len_q) > 32'(STORE_DEPTH)) begin
      len_eff = (AW+1)'(STORE_DEPTH);
    end else begin
      len_eff = (AW+1)'(cfg_len_q);
    end
  end

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign delay_sel = cfg_use_delay_q ? delay_samples_i : cfg_delay_q;
  assign idel_raw  = delay_sel[DELAY_BITS-1:FRACTION_BITS];

  // integer delay saturates at the wrap point minus one
  assign idel_clamp = (32'(idel_raw) > (32'(len_eff) - 32'd1)) ?
                      AW'(len_eff - (AW+1)'(1)) : AW'(idel_raw);
  assign wp_clamp   = ((AW+1)'(wp_q) >= len_eff) ? '0 : wp_q;

  // read position with wrap, and its neighbor slot
  assign rp_sum  = ((AW+1)'(cur_wp_q) >= (AW+1)'(idel_q)) ?
                   (AW+1)'(cur_wp_q) - (AW+1)'(idel_q) :
                   (AW+1)'(cur_wp_q) + len_eff - (AW+1)'(idel_q);
  assign rp2_inc = (AW+1)'(rp_q) + (AW+1)'(1);
  assign rp2     = (rp2_inc >= len_eff) ? '0 : AW'(rp2_inc);
  assign wp_inc  = (AW+1)'(cur_wp_q) + (AW+1)'(1);

  // shared multiplier: interpolation step, then feedback gain
  always_comb begin
    if (state_q == S_MUL2) begin
      mul_a = (SAMPLE_BITS+1)'(y_q);
      mul_b = MB'(gain_q);
    end else begin
      mul_a = diff_q;
      mul_b = $signed(MB'({1'b0, frac_q}));
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // round half up folded in as a carry
  assign y_wide   = PW'(s1_q) + (prod_q >>> FRACTION_BITS) +
                    $signed(PW'(prod_q[FRACTION_BITS-1]));
  assign sum_wide = PW'(x_q) + (prod_q >>> GAIN_FRAC) +
                    $signed(PW'(prod_q[GAIN_FRAC-1]));

  always_comb begin
    priority if (sum_wide > SAT_HI) begin
      wr_val = SAMPLE_BITS'(SAT_HI);
    end else if (sum_wide < SAT_LO) begin
      wr_val = SAMPLE_BITS'(SAT_LO);
    end else begin
      wr_val = SAMPLE_BITS'(sum_wide);
    end
  end

  assign commit = (state_q == S_WR) && !(out_valid_q && out_stall_i);
  assign mem_we = (state_q == S_CLR) || commit;
  assign mem_wa = (state_q == S_CLR) ? clr_q : cur_wp_q;
  assign mem_wd = (state_q == S_CLR) ? '0 : wr_val;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_wa] <= mem_wd;
    end
    rd1_q <= store_q[rp_q];
    rd2_q <= store_q[rp2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q       <= LEN_RESET;
      cfg_delay_q     <= DELAY_RESET;
      cfg_fb_q        <= GAIN_RESET;
      cfg_use_delay_q <= 1'b0;
      cfg_use_fb_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_BUFFER_LENGTH:     cfg_len_q       <= cfg_wdata_i[LEN_BITS-1:0];
        CFG_DEFAULT_DELAY:     cfg_delay_q     <= cfg_wdata_i[DELAY_BITS-1:0];
        CFG_DEFAULT_FEEDBACK:  cfg_fb_q        <= $signed(cfg_wdata_i[GAIN_BITS-1:0]);
        CFG_USE_ITEM_DELAY:    cfg_use_delay_q <= cfg_wdata_i[0];
        CFG_USE_ITEM_FEEDBACK: cfg_use_fb_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      wp_q         <= '0;
      cur_wp_q     <= '0;
      idel_q       <= '0;
      rp_q         <= '0;
      frac_q       <= '0;
      gain_q       <= '0;
      x_q          <= '0;
      s1_q         <= '0;
      diff_q       <= '0;
      y_q          <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      wet_sample_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(STORE_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            x_q      <= in_sample_i;
            gain_q   <= cfg_use_fb_q ? feedback_gain_i : cfg_fb_q;
            frac_q   <= delay_sel[FRACTION_BITS-1:0];
            idel_q   <= idel_clamp;
            cur_wp_q <= wp_clamp;
            state_q  <= S_RP;
          end
        end
        S_RP: begin
          rp_q    <= AW'(rp_sum);
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= S_DIF;
        end
        S_DIF: begin
          s1_q    <= rd1_q;
          diff_q  <= (SAMPLE_BITS+1)'(rd2_q) - (SAMPLE_BITS+1)'(rd1_q);
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          prod_q  <= mul_p;
          state_q <= S_Y;
        end
        S_Y: begin
          y_q     <= SAMPLE_BITS'(y_wide);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          prod_q  <= mul_p;
          state_q <= S_WR;
        end
        S_WR: begin
          // holds until the output register is free
          if (commit) begin
            out_valid_q  <= 1'b1;
            wet_sample_q <= y_q;
            wp_q         <= (wp_inc >= len_eff) ? '0 : AW'(wp_inc);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign wet_sample_o = wet_sample_q;

endmodule

[sv/ifd_checker.sv]
// ----------------------------------------------------------------------------
// ifd_checker
// Port-level checks for the interpolated feedback delay line.
// ----------------------------------------------------------------------------
module ifd_checker import ifd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input logic [DELAY_BITS-1:0]         delay_samples_i,
  input logic signed [GAIN_BITS-1:0]   feedback_gain_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] wet_sample_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(wet_sample_o))
    else $error("stalled output beat changed");

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_sample_i) &&
    $stable(delay_samples_i) && $stable(feedback_gain_i))
    else $error("stalled input beat changed");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while item in flight");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in flight");

  // store clearing keeps input stalled right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input open during store clearing");

endmodule

bind interpolated_feedback_delay ifd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ifd_checker (.*);
